@@ src/sdmm_pkg.sv @@
`default_nettype none

package sdmm_pkg;

   // Store dimensions
   localparam int ROWS_CAP       = 256;
   localparam int COLS_CAP       = 256;
   localparam int MAX_DENSE_COLS = 16;

   localparam int ROW_W  = $clog2(ROWS_CAP);
   localparam int COL_W  = $clog2(COLS_CAP);
   localparam int KCOL_W = $clog2(MAX_DENSE_COLS);

   localparam int RES_DEPTH    = ROWS_CAP * MAX_DENSE_COLS;
   localparam int DENSE_DEPTH  = COLS_CAP * MAX_DENSE_COLS;
   localparam int RES_ADDR_W   = ROW_W + KCOL_W;
   localparam int DENSE_ADDR_W = COL_W + KCOL_W;

   // Field widths
   localparam int CMD_W      = 2;
   localparam int IDX_W      = 8;
   localparam int VAL_W      = 32;
   localparam int ACC_W      = 64;
   localparam int DIM_W      = 9;
   localparam int DCOLS_W    = 5;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 9;

   // Command codes
   localparam logic [CMD_W-1:0] CMD_WRITE = 2'd0;
   localparam logic [CMD_W-1:0] CMD_MAC   = 2'd1;
   localparam logic [CMD_W-1:0] CMD_READ  = 2'd2;
   localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd3;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_SPARSE_ROWS = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARSE_COLS = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_DENSE_COLS  = 2'd2;

   // Controller to datapath commands
   typedef struct packed {
      logic              accept;
      logic              mac_issue;
      logic [KCOL_W-1:0] mac_col;
      logic              set_valid;
      logic              load_rsp;
   } ctl_cmd_type;

   // Datapath to controller status
   typedef struct packed {
      logic [CMD_W-1:0] command;
      logic             err;
   } dp_status_type;

endpackage

`default_nettype wire

@@ src/sdmm_req_if.sv @@
`default_nettype none

interface sdmm_req_if import sdmm_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic [CMD_W-1:0]        command;
   logic [IDX_W-1:0]        row_index;
   logic [IDX_W-1:0]        col_index;
   logic signed [VAL_W-1:0] value;

   modport source (output valid, command, row_index, col_index, value, input ready);
   modport sink   (input valid, command, row_index, col_index, value, output ready);
endinterface

`default_nettype wire

@@ src/sdmm_rsp_if.sv @@
`default_nettype none

interface sdmm_rsp_if import sdmm_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic signed [ACC_W-1:0] result_value;
   logic                    status;

   modport source (output valid, result_value, status, input ready);
   modport sink   (input valid, result_value, status, output ready);
endinterface

`default_nettype wire

@@ src/sdmm_ram.sv @@
`default_nettype none

module sdmm_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // One write port and one registered read port; read data holds between reads.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

@@ src/sdmm_ctrl.sv @@
`default_nettype none

module sdmm_ctrl import sdmm_pkg::*; (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_valid,
   output logic               req_ready,
   output logic               rsp_valid,
   input  wire logic          rsp_ready,
   input  wire dp_status_type status,
   output ctl_cmd_type        ctl
);

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_MAC   = 2'd1;
   localparam logic [1:0] ST_DRAIN = 2'd2;
   localparam logic [1:0] ST_FIN   = 2'd3;

   logic [1:0]        state_ff, state_in;
   logic [KCOL_W-1:0] k_ff, k_in;
   logic              drain_ff, drain_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              accept;
   logic              load;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign load      = (state_ff == ST_FIN) && (!rsp_valid_ff || rsp_ready);

   // Next state: an error-free accumulate walks every result column and drains, all else goes straight to finish.
   always_comb begin
      state_in = state_ff;
      k_in     = k_ff;
      drain_in = drain_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               k_in = '0;
               if (status.command == CMD_MAC && !status.err) begin
                  state_in = ST_MAC;
               end else begin
                  state_in = ST_FIN;
               end
            end
         end
         ST_MAC: begin
            k_in = k_ff + 1'b1;
            if (k_ff == KCOL_W'(MAX_DENSE_COLS - 1)) begin
               state_in = ST_DRAIN;
               drain_in = 1'b0;
            end
         end
         ST_DRAIN: begin
            drain_in = 1'b1;
            if (drain_ff) begin
               state_in = ST_FIN;
            end
         end
         ST_FIN: begin
            if (load) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // The output register frees itself when the sink takes the transaction.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         k_ff         <= '0;
         drain_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         k_ff         <= k_in;
         drain_ff     <= drain_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign ctl.accept    = accept;
   assign ctl.mac_issue = (state_ff == ST_MAC);
   assign ctl.mac_col   = k_ff;
   assign ctl.set_valid = (state_ff == ST_DRAIN) && drain_ff;
   assign ctl.load_rsp  = load;

endmodule

`default_nettype wire

@@ src/sdmm_datapath.sv @@
`default_nettype none

module sdmm_datapath import sdmm_pkg::*; (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic [CMD_W-1:0]        req_command,
   input  wire logic [IDX_W-1:0]        req_row,
   input  wire logic [IDX_W-1:0]        req_col,
   input  wire logic signed [VAL_W-1:0] req_value,
   input  wire logic                    csr_we,
   input  wire logic [CSR_IDX_W-1:0]    csr_index,
   input  wire logic [CSR_DATA_W-1:0]   csr_wdata,
   input  wire ctl_cmd_type             ctl,
   output dp_status_type                status,
   output logic signed [ACC_W-1:0]      rsp_result,
   output logic                         rsp_status
);

   // Configuration registers
   logic [DIM_W-1:0]   sparse_rows_ff;
   logic [DIM_W-1:0]   sparse_cols_ff;
   logic [DCOLS_W-1:0] dense_cols_ff;
   logic [DIM_W-1:0]   dim_wr;
   logic [DCOLS_W-1:0] dcols_wr;

   // Item held while it is worked on
   logic [CMD_W-1:0]        cmd_ff;
   logic [IDX_W-1:0]        row_ff;
   logic [IDX_W-1:0]        col_ff;
   logic signed [VAL_W-1:0] val_ff;
   logic                    err_ff;
   logic                    err;

   // Result rows that hold data since the last clear
   logic [ROWS_CAP-1:0] row_valid_ff;
   logic                row_valid;

   // Memory ports
   logic                    dense_we;
   logic [DENSE_ADDR_W-1:0] dense_waddr;
   logic [DENSE_ADDR_W-1:0] dense_raddr;
   logic [VAL_W-1:0]        dense_rd;
   logic                    res_re;
   logic [RES_ADDR_W-1:0]   res_raddr;
   logic [RES_ADDR_W-1:0]   res_waddr;
   logic [ACC_W-1:0]        res_rd;
   logic signed [ACC_W-1:0] res_old;

   // Multiply-accumulate pipeline
   logic                    p1_ff;
   logic [KCOL_W-1:0]       k1_ff;
   logic                    p2_ff;
   logic [KCOL_W-1:0]       k2_ff;
   logic signed [ACC_W-1:0] prod_ff, prod_in;
   logic signed [ACC_W-1:0] old_ff;
   logic                    use_ff;
   logic signed [ACC_W:0]   sum_wide;
   logic signed [ACC_W-1:0] sum_sat;
   logic signed [ACC_W-1:0] acc_wr;

   logic signed [ACC_W-1:0] rsp_result_ff;
   logic                    rsp_status_ff;

   // Clamp written dimensions into their legal range
   always_comb begin
      dim_wr = csr_wdata;
      if (dim_wr == '0) begin
         dim_wr = DIM_W'(1);
      end
      dcols_wr = csr_wdata[DCOLS_W-1:0];
      if (dcols_wr == '0) begin
         dcols_wr = DCOLS_W'(1);
      end else if (dcols_wr > DCOLS_W'(MAX_DENSE_COLS)) begin
         dcols_wr = DCOLS_W'(MAX_DENSE_COLS);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sparse_rows_ff <= DIM_W'(ROWS_CAP);
         sparse_cols_ff <= DIM_W'(COLS_CAP);
         dense_cols_ff  <= DCOLS_W'(MAX_DENSE_COLS);
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_SPARSE_ROWS: begin
               sparse_rows_ff <= (dim_wr > DIM_W'(ROWS_CAP)) ? DIM_W'(ROWS_CAP) : dim_wr;
            end
            CSR_SPARSE_COLS: begin
               sparse_cols_ff <= (dim_wr > DIM_W'(COLS_CAP)) ? DIM_W'(COLS_CAP) : dim_wr;
            end
            CSR_DENSE_COLS: begin
               dense_cols_ff <= dcols_wr;
            end
            default: begin
            end
         endcase
      end
   end

   // Index check against the configured dimensions
   always_comb begin
      unique case (req_command)
         CMD_WRITE: err = !(({1'b0, req_row} < sparse_cols_ff) &&
                            (DIM_W'(req_col) < DIM_W'(dense_cols_ff)));
         CMD_MAC:   err = !(({1'b0, req_row} < sparse_rows_ff) &&
                            ({1'b0, req_col} < sparse_cols_ff));
         CMD_READ:  err = !(({1'b0, req_row} < sparse_rows_ff) &&
                            (DIM_W'(req_col) < DIM_W'(dense_cols_ff)));
         default:   err = 1'b0;
      endcase
   end

   assign status.command = req_command;
   assign status.err     = err;

   // Capture the transaction on acceptance
   always_ff @(posedge clock) begin
      if (ctl.accept) begin
         cmd_ff <= req_command;
         row_ff <= req_row;
         col_ff <= req_col;
         val_ff <= req_value;
         err_ff <= err;
      end
   end

   // Row valid bits: a clear drops them all, a finished accumulate sets its row
   always_ff @(posedge clock) begin
      if (reset) begin
         row_valid_ff <= '0;
      end else if (ctl.accept && req_command == CMD_CLEAR) begin
         row_valid_ff <= '0;
      end else if (ctl.set_valid) begin
         row_valid_ff[row_ff[ROW_W-1:0]] <= 1'b1;
      end
   end

   assign row_valid = row_valid_ff[row_ff[ROW_W-1:0]];

   // Dense store: written straight from the accepted transaction
   assign dense_we    = ctl.accept && (req_command == CMD_WRITE) && !err;
   assign dense_waddr = {req_row[COL_W-1:0], req_col[KCOL_W-1:0]};
   assign dense_raddr = {col_ff[COL_W-1:0], ctl.mac_col};

   sdmm_ram #(
      .WIDTH (VAL_W),
      .DEPTH (DENSE_DEPTH)
   ) u_dense_ram (
      .clock   (clock),
      .wr_en   (dense_we),
      .wr_addr (dense_waddr),
      .wr_data (req_value),
      .rd_en   (ctl.mac_issue),
      .rd_addr (dense_raddr),
      .rd_data (dense_rd)
   );

   // Result store: read for a column update or for a read-back
   assign res_re    = ctl.mac_issue || (ctl.accept && (req_command == CMD_READ) && !err);
   assign res_raddr = ctl.mac_issue ? {row_ff[ROW_W-1:0], ctl.mac_col}
                                    : {req_row[ROW_W-1:0], req_col[KCOL_W-1:0]};
   assign res_waddr = {row_ff[ROW_W-1:0], k2_ff};

   sdmm_ram #(
      .WIDTH (ACC_W),
      .DEPTH (RES_DEPTH)
   ) u_result_ram (
      .clock   (clock),
      .wr_en   (p2_ff),
      .wr_addr (res_waddr),
      .wr_data (acc_wr),
      .rd_en   (res_re),
      .rd_addr (res_raddr),
      .rd_data (res_rd)
   );

   // A row that has not been written since the last clear reads as zero.
   assign res_old = row_valid ? $signed(res_rd) : '0;

   // First stage: multiply the nonzero by the dense word (both sign-extended)
   assign prod_in = ACC_W'(val_ff) * ACC_W'($signed(dense_rd));

   always_ff @(posedge clock) begin
      if (reset) begin
         p1_ff <= 1'b0;
         p2_ff <= 1'b0;
      end else begin
         p1_ff <= ctl.mac_issue;
         p2_ff <= p1_ff;
      end
   end

   always_ff @(posedge clock) begin
      k1_ff   <= ctl.mac_col;
      k2_ff   <= k1_ff;
      prod_ff <= prod_in;
      old_ff  <= res_old;
      use_ff  <= (DCOLS_W'(k1_ff) < dense_cols_ff);
   end

   // Second stage: saturating add; inactive columns are written back unchanged.
   assign sum_wide = {old_ff[ACC_W-1], old_ff} + {prod_ff[ACC_W-1], prod_ff};

   always_comb begin
      if (sum_wide[ACC_W] != sum_wide[ACC_W-1]) begin
         sum_sat = sum_wide[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
      end else begin
         sum_sat = sum_wide[ACC_W-1:0];
      end
   end

   assign acc_wr = use_ff ? sum_sat : old_ff;

   // Output register
   always_ff @(posedge clock) begin
      if (ctl.load_rsp) begin
         rsp_status_ff <= err_ff;
         rsp_result_ff <= (cmd_ff == CMD_READ && !err_ff) ? res_old : '0;
      end
   end

   assign rsp_result = rsp_result_ff;
   assign rsp_status = rsp_status_ff;

endmodule

`default_nettype wire

@@ src/sparse_dense_matmul_accumulate.sv @@
// Order of work: an accumulate transaction issues one multiply-accumulate per cycle over all
// 16 result columns, drains the pipeline, then loads its response once the output register is
// free; every other command loads its response directly. One transaction is worked on at a time:
// a new one is accepted only after the response is loaded and the block has returned to idle.
// Reset (synchronous) restores the default dimensions and marks every result row empty
// at once, so results read as zero; the dense store is left as it was.
`default_nettype none

module sparse_dense_matmul_accumulate import sdmm_pkg::*; (
   input  wire logic                  clock,
   input  wire logic                  reset,
   sdmm_req_if.sink                   req_ch,
   sdmm_rsp_if.source                 rsp_ch,
   input  wire logic                  csr_we,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata
);

   ctl_cmd_type   ctl;
   dp_status_type status;

   // Sequencing of each transaction
   sdmm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .status    (status),
      .ctl       (ctl)
   );

   // Stores, arithmetic and configuration
   sdmm_datapath u_datapath (
      .clock       (clock),
      .reset       (reset),
      .req_command (req_ch.command),
      .req_row     (req_ch.row_index),
      .req_col     (req_ch.col_index),
      .req_value   (req_ch.value),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .ctl         (ctl),
      .status      (status),
      .rsp_result  (rsp_ch.result_value),
      .rsp_status  (rsp_ch.status)
   );

   // Only one transaction is in flight.
   assert property (@(posedge clock) disable iff (reset)
      (req_ch.valid && req_ch.ready) |=> !req_ch.ready)
      else $error("transaction accepted while another is in flight");

   // Column updates never overlap acceptance of a new transaction.
   assert property (@(posedge clock) disable iff (reset)
      ctl.mac_issue |-> !req_ch.ready)
      else $error("column update issued while idle");

   // An index error never returns data.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && rsp_ch.status) |-> (rsp_ch.result_value == '0))
      else $error("error response carries data");

   // A response is loaded only into a free or draining output register.
   assert property (@(posedge clock) disable iff (reset)
      ctl.load_rsp |-> (!rsp_ch.valid || rsp_ch.ready))
      else $error("response overwritten before it was taken");

endmodule

`default_nettype wire
